>>> hdl/serial_status_frame_receiver_macros.svh
// assertion macros shared by the checker of the serial status frame receiver
`ifndef SERIAL_STATUS_FRAME_RECEIVER_MACROS_SVH
`define SERIAL_STATUS_FRAME_RECEIVER_MACROS_SVH

// implication checked in the same cycle, ignored while reset is low
`define SFR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the cycle after the antecedent, ignored while reset is low
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/sfr_pkg.sv
// types and constants of the serial status frame receiver
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

    // kind of input item
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // configuration register indexes
    localparam logic CFG_START_BYTE = 1'b0;
    localparam logic CFG_TIMEOUT    = 1'b1;

    localparam logic [7:0]  START_BYTE_RESET = 8'd170;
    localparam logic [15:0] TIMEOUT_RESET    = 16'd100;
    localparam logic [15:0] IDLE_MAX         = 16'hFFFF;

    // frame event codes
    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_GOOD     = 2'd1,
        EV_MISMATCH = 2'd2
    } sfr_event_t;

    // position inside a frame
    typedef enum logic [2:0] {
        POS_HUNT  = 3'd0,
        POS_D0    = 3'd1,
        POS_D1    = 3'd2,
        POS_D2    = 3'd3,
        POS_CHECK = 3'd4
    } sfr_pos_t;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [15:0] timeout_ticks;
    } sfr_cfg_t;

    typedef struct packed {
        logic signed [15:0] speed_value;
        logic [7:0]         fault_value;
        logic               link_ok;
        sfr_event_t         frame_event;
    } sfr_result_t;

endpackage

`default_nettype wire

>>> hdl/sfr_core.sv
// frame parser and link supervisor of the serial status frame receiver
`timescale 1ns / 1ps
`default_nettype none

module sfr_core
    import sfr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        take,
    input  wire logic        cmd,
    input  wire logic [7:0]  rx_byte,
    input  wire sfr_cfg_t    cfg,
    output sfr_result_t      result
);

    sfr_pos_t           pos_reg, pos_next;
    logic [7:0]         store_reg [0:2];
    logic [7:0]         store_next [0:2];
    logic [7:0]         xor_reg, xor_next;
    logic signed [15:0] speed_reg, speed_next;
    logic [7:0]         fault_reg, fault_next;
    logic               link_reg, link_next;
    logic [15:0]        idle_reg, idle_next;
    logic [15:0]        idle_tick;
    sfr_event_t         event_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_HUNT;
            xor_reg   <= 8'd0;
            speed_reg <= 16'sd0;
            fault_reg <= 8'd0;
            link_reg  <= 1'b0;
            idle_reg  <= 16'd0;
        end
        else if (take)
        begin
            pos_reg   <= pos_next;
            xor_reg   <= xor_next;
            speed_reg <= speed_next;
            fault_reg <= fault_next;
            link_reg  <= link_next;
            idle_reg  <= idle_next;
        end
    end

    // frame bytes are always written before they are read
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            store_reg[0] <= store_next[0];
            store_reg[1] <= store_next[1];
            store_reg[2] <= store_next[2];
        end
    end

    assign idle_tick = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 16'd1;

    always_comb
    begin
        pos_next      = pos_reg;
        store_next[0] = store_reg[0];
        store_next[1] = store_reg[1];
        store_next[2] = store_reg[2];
        xor_next      = xor_reg;
        speed_next    = speed_reg;
        fault_next    = fault_reg;
        link_next     = link_reg;
        idle_next     = idle_reg;
        event_next    = EV_NONE;
        if (cmd == CMD_BYTE)
        begin
            unique case (pos_reg)
                POS_HUNT:
                begin
                    if (rx_byte == cfg.start_byte)
                    begin
                        pos_next = POS_D0;
                        xor_next = 8'd0;
                    end
                end
                POS_D0:
                begin
                    store_next[0] = rx_byte;
                    xor_next      = xor_reg ^ rx_byte;
                    pos_next      = POS_D1;
                end
                POS_D1:
                begin
                    store_next[1] = rx_byte;
                    xor_next      = xor_reg ^ rx_byte;
                    pos_next      = POS_D2;
                end
                POS_D2:
                begin
                    store_next[2] = rx_byte;
                    xor_next      = xor_reg ^ rx_byte;
                    pos_next      = POS_CHECK;
                end
                POS_CHECK:
                begin
                    if (rx_byte == xor_reg)
                    begin
                        speed_next = $signed({store_reg[0], store_reg[1]});
                        fault_next = store_reg[2];
                        idle_next  = 16'd0;
                        link_next  = 1'b1;
                        event_next = EV_GOOD;
                    end
                    else
                    begin
                        event_next = EV_MISMATCH;
                    end
                    pos_next = POS_HUNT;
                end
                default:
                begin
                    pos_next = POS_HUNT;
                end
            endcase
        end
        else
        begin
            // compare after the saturating increment
            idle_next = idle_tick;
            if (idle_tick > cfg.timeout_ticks)
            begin
                link_next = 1'b0;
            end
        end
    end

    assign result.speed_value = speed_next;
    assign result.fault_value = fault_next;
    assign result.link_ok     = link_next;
    assign result.frame_event = event_next;

endmodule

`default_nettype wire

>>> hdl/serial_status_frame_receiver.sv
// top level of the serial status frame receiver
`timescale 1ns / 1ps
`default_nettype none

// serial status frame receiver: takes one item per cycle on the slave stream, either a
// received byte (s_tuser low, byte in s_tdata) or one timer tick (s_tuser high). bytes are
// parsed as start byte, three data bytes and a checksum byte; a frame whose checksum equals
// the xor of its data bytes latches a signed big-endian speed and a fault byte, clears the
// idle tick count and raises link_ok. ticks advance a saturating idle count and link_ok
// falls once it exceeds timeout_ticks. every item gives exactly one result item in the
// cycle after it is accepted; the update is one pass of logic from the frame state to the
// output register. s_tready is low only while a result sits in the output register and
// m_tready is low. the user must write start_byte and timeout_ticks on the cfg port only
// while the stream is idle (not enforced by the block); they take effect on the next item.

module serial_status_frame_receiver
    import sfr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_wdata,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte[7:0]
    input  wire logic        s_tuser,   // cmd
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // speed_value[15:0], fault_value[23:16]
    output logic [2:0]       m_tuser    // link_ok[0], frame_event[2:1]
);

    sfr_cfg_t    cfg_reg;
    sfr_result_t result;
    sfr_result_t out_reg;
    logic        m_tvalid_reg;
    logic        take;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte    <= START_BYTE_RESET;
            cfg_reg.timeout_ticks <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_BYTE: cfg_reg.start_byte    <= cfg_wdata[7:0];
                CFG_TIMEOUT:    cfg_reg.timeout_ticks <= cfg_wdata;
                default:        cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // output register doubles as the skid between the two sides
    assign s_tready = !m_tvalid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    sfr_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .cmd     (s_tuser),
        .rx_byte (s_tdata),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg.fault_value, out_reg.speed_value};
    assign m_tuser  = {out_reg.frame_event, out_reg.link_ok};

endmodule

`default_nettype wire

>>> hdl/sfr_checker.sv
// port-level checker of the serial status frame receiver and its bind
`timescale 1ns / 1ps
`default_nettype none

`include "serial_status_frame_receiver_macros.svh"

module sfr_checker
    import sfr_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [2:0]  m_tuser
);

    `SFR_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !m_tvalid, s_tready, "not ready while empty")
    `SFR_ASSERT_SAME(a_event_code, clk, rst_n, m_tvalid, m_tuser[2:1] != 2'd3, "bad event code")
    `SFR_ASSERT_SAME(a_good_sets_link, clk, rst_n, m_tvalid && (m_tuser[2:1] == EV_GOOD),
        m_tuser[0], "good frame without link")
    `SFR_ASSERT_NEXT(a_stall_holds, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled item changed")

endmodule

bind serial_status_frame_receiver sfr_checker u_sfr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
